// ===== rtl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg : shared types and constants of the deque engine
// Capacity, field widths, opcode and status codes, cell commands and the
// control bundle that the sequencer broadcasts to the row of cells.
// ---------------------------------------------------------------------------
package dq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 64;
   localparam int OP_W     = 4;
   localparam int STAT_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_PUSHF = 4'd0,
      OP_PUSHB = 4'd1,
      OP_POPF  = 4'd2,
      OP_POPB  = 4'd3,
      OP_FRONT = 4'd4,
      OP_BACK  = 4'd5,
      OP_SIZE  = 4'd6,
      OP_EMPTY = 4'd7,
      OP_CLEAR = 4'd8,
      OP_PRINT = 4'd9,
      OP_EXIT  = 4'd10
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_VALUE      = 3'd0,
      STAT_OK         = 3'd1,
      STAT_EMPTY_ERR  = 3'd2,
      STAT_SIZE       = 3'd3,
      STAT_EMPTY_FLAG = 3'd4,
      STAT_EMPTY_LIST = 3'd5,
      STAT_BYE        = 3'd6,
      STAT_FULL       = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_PRINT = 2'd1,
      ST_HALT  = 2'd2
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_PUSHF  = 3'd1,
      CELL_PUSHB  = 3'd2,
      CELL_POPF   = 3'd3,
      CELL_ROTATE = 3'd4
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic [CNT_W-1:0] count;
   } cell_ctrl_type;

   localparam int ADDR_W      = 3;
   localparam int CSR_DATA_W  = 32;

endpackage

// ===== rtl/dq_cell.sv =====
// ---------------------------------------------------------------------------
// dq_cell : one storage cell of the deque row
// Holds the element at its position from the front and moves data to or
// from its neighbours as the broadcast command says.
// ---------------------------------------------------------------------------
module dq_cell (
   input  logic                       clock,
   input  dq_pkg::cell_ctrl_type      cell_ctrl,
   input  logic [dq_pkg::IDX_W-1:0]   cell_index,
   input  logic [dq_pkg::DATA_W-1:0]  prev_value,
   input  logic [dq_pkg::DATA_W-1:0]  next_value,
   input  logic [dq_pkg::DATA_W-1:0]  front_value,
   input  logic [dq_pkg::DATA_W-1:0]  push_value,
   output logic [dq_pkg::DATA_W-1:0]  value,
   output logic [dq_pkg::DATA_W-1:0]  tap_value
);

   logic [dq_pkg::DATA_W-1:0] value_ff;
   logic [dq_pkg::DATA_W-1:0] value_in;
   logic [dq_pkg::CNT_W-1:0]  pos;
   logic [dq_pkg::CNT_W-1:0]  pos_next;

   assign pos      = dq_pkg::CNT_W'(cell_index);
   assign pos_next = pos + dq_pkg::CNT_W'(1);

   // choose the new content of this cell
   always_comb begin
      value_in = value_ff;
      case (cell_ctrl.cmd)
         dq_pkg::CELL_PUSHF: begin
            value_in = prev_value;
         end
         dq_pkg::CELL_PUSHB: begin
            if (pos == cell_ctrl.count) begin
               value_in = push_value;
            end
         end
         dq_pkg::CELL_POPF: begin
            value_in = next_value;
         end
         dq_pkg::CELL_ROTATE: begin
            if (pos_next == cell_ctrl.count) begin
               value_in = front_value;
            end else if (pos_next < cell_ctrl.count) begin
               value_in = next_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // hold the element
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   // offer the element when this cell is the back of the queue
   assign tap_value = (pos_next == cell_ctrl.count) ? value_ff : '0;

endmodule

// ===== rtl/dq_ctrl.sv =====
// ---------------------------------------------------------------------------
// dq_ctrl : command sequencer of the deque engine
// Decodes each command beat, keeps the element count, drives the cell row
// and owns the result register, including the multi-beat print listing.
// ---------------------------------------------------------------------------
module dq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        verbose,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dq_pkg::OP_W-1:0]     req_opcode,
   input  logic [dq_pkg::DATA_W-1:0]   front_value,
   input  logic [dq_pkg::DATA_W-1:0]   back_value,
   output dq_pkg::cell_ctrl_type       cell_ctrl,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dq_pkg::STAT_W-1:0]   rsp_status,
   output logic [dq_pkg::DATA_W-1:0]   rsp_result_value,
   output logic                        rsp_last
);

   dq_pkg::state_type          state_ff, state_in;
   logic [dq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [dq_pkg::CNT_W-1:0]   remain_ff, remain_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   dq_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [dq_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_load;
   dq_pkg::cell_cmd_type       cell_cmd;
   logic                       out_free;
   logic                       accept;
   logic                       empty;
   logic                       full;
   dq_pkg::op_type             op;

   assign op       = dq_pkg::op_type'(req_opcode);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == dq_pkg::CNT_W'(dq_pkg::CAPACITY));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = ((state_ff == dq_pkg::ST_IDLE) && out_free)
                    || (state_ff == dq_pkg::ST_HALT);
   assign accept   = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (accept && verbose && (op == dq_pkg::OP_PRINT) && !empty) begin
               state_in = dq_pkg::ST_PRINT;
            end else if (accept && verbose && (op == dq_pkg::OP_EXIT)) begin
               state_in = dq_pkg::ST_HALT;
            end
         end
         dq_pkg::ST_PRINT: begin
            if (out_free && (remain_ff == dq_pkg::CNT_W'(1))) begin
               state_in = dq_pkg::ST_IDLE;
            end
         end
         dq_pkg::ST_HALT: begin
            state_in = dq_pkg::ST_HALT;
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   // cell commands, count update and result beat
   always_comb begin
      cell_cmd      = dq_pkg::CELL_HOLD;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_load      = 1'b0;
      rsp_status_in = dq_pkg::STAT_OK;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  dq_pkg::OP_PUSHF, dq_pkg::OP_PUSHB: begin
                     if (full) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = dq_pkg::STAT_FULL;
                     end else begin
                        cell_cmd = (op == dq_pkg::OP_PUSHF) ? dq_pkg::CELL_PUSHF
                                                            : dq_pkg::CELL_PUSHB;
                        count_in = count_ff + dq_pkg::CNT_W'(1);
                        rsp_load = verbose;
                     end
                  end
                  dq_pkg::OP_POPF, dq_pkg::OP_POPB,
                  dq_pkg::OP_FRONT, dq_pkg::OP_BACK: begin
                     rsp_load = 1'b1;
                     if (empty) begin
                        rsp_status_in = dq_pkg::STAT_EMPTY_ERR;
                        rsp_value_in  = '1;
                     end else begin
                        rsp_status_in = dq_pkg::STAT_VALUE;
                        if ((op == dq_pkg::OP_POPF) || (op == dq_pkg::OP_FRONT)) begin
                           rsp_value_in = front_value;
                        end else begin
                           rsp_value_in = back_value;
                        end
                        if (op == dq_pkg::OP_POPF) begin
                           cell_cmd = dq_pkg::CELL_POPF;
                        end
                        if ((op == dq_pkg::OP_POPF) || (op == dq_pkg::OP_POPB)) begin
                           count_in = count_ff - dq_pkg::CNT_W'(1);
                        end
                     end
                  end
                  dq_pkg::OP_SIZE: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = dq_pkg::STAT_SIZE;
                     rsp_value_in  = dq_pkg::DATA_W'(count_ff);
                  end
                  dq_pkg::OP_EMPTY: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = dq_pkg::STAT_EMPTY_FLAG;
                     rsp_value_in  = dq_pkg::DATA_W'(empty);
                  end
                  dq_pkg::OP_CLEAR: begin
                     if (verbose) begin
                        count_in = '0;
                        rsp_load = 1'b1;
                     end
                  end
                  dq_pkg::OP_PRINT: begin
                     if (verbose) begin
                        if (empty) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = dq_pkg::STAT_EMPTY_LIST;
                        end else begin
                           remain_in = count_ff;
                        end
                     end
                  end
                  dq_pkg::OP_EXIT: begin
                     if (verbose) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = dq_pkg::STAT_BYE;
                     end
                  end
                  default: begin
                     rsp_load = 1'b0;
                  end
               endcase
            end
         end
         dq_pkg::ST_PRINT: begin
            // emit the front and rotate it to the back
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = dq_pkg::STAT_VALUE;
               rsp_value_in  = front_value;
               rsp_last_in   = (remain_ff == dq_pkg::CNT_W'(1));
               cell_cmd      = dq_pkg::CELL_ROTATE;
               remain_in     = remain_ff - dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::ST_HALT: begin
            rsp_load = 1'b0;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign cell_ctrl.cmd    = cell_cmd;
   assign cell_ctrl.count  = count_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   // count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::CNT_W'(dq_pkg::CAPACITY))
      else $error("element count above capacity");

   // a listing never runs on an empty queue or past its element count
   a_print_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::ST_PRINT) |-> (remain_ff != '0) && (remain_ff <= count_ff))
      else $error("print listing out of range");

   // a halted block raises no new result beat
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::ST_HALT) |=> !rsp_load)
      else $error("result raised while halted");

   // the cell row rotates only on a loaded beat of a listing
   a_cell_move: assert property (@(posedge clock) disable iff (reset)
      (cell_cmd == dq_pkg::CELL_ROTATE) |-> rsp_load && (state_ff == dq_pkg::ST_PRINT))
      else $error("rotation outside a listing beat");

endmodule

// ===== rtl/double_ended_queue_engine_unit.sv =====
// Results: a result beat appears in the register in the cycle after its command beat;
// a listing's first beat is loaded once the sequencer has entered the print state, then
// one beat per cycle while the output is free. Intake: one command per cycle while idle
// and the output is free; print holds the input until the listing of every stored element,
// which rotates the cell row one place per beat, is done. Output back-pressure stalls both
// listing and command intake. Reset clears count, listing and halt state and sets verbose
// mode; cell contents are not cleared.
// ---------------------------------------------------------------------------
// double_ended_queue_engine_unit : bounded deque of signed 64-bit values
// A row of shifting cells holds the elements front to back; a sequencer
// decodes commands and a small register port selects the dialect.
// ---------------------------------------------------------------------------
module double_ended_queue_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dq_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [dq_pkg::DATA_W-1:0]  req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dq_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0]  rsp_result_value,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dq_pkg::ADDR_W-1:0]         paddr,
   input  logic [dq_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dq_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                              pready
);

   logic                      verbose_ff, verbose_in;
   logic                      csr_write;
   dq_pkg::cell_ctrl_type     cell_ctrl;
   logic [dq_pkg::DATA_W-1:0] cell_value [dq_pkg::CAPACITY];
   logic [dq_pkg::DATA_W-1:0] cell_tap   [dq_pkg::CAPACITY];
   logic [dq_pkg::DATA_W-1:0] back_value;
   logic [dq_pkg::DATA_W-1:0] rsp_value_raw;

   // register port: one mode bit at the first word
   assign pready     = 1'b1;
   assign csr_write  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
   assign verbose_in = csr_write ? pwdata[0] : verbose_ff;
   assign prdata     = (paddr[2] == 1'b0) ? dq_pkg::CSR_DATA_W'(verbose_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         verbose_ff <= 1'b1;
      end else begin
         verbose_ff <= verbose_in;
      end
   end

   // row of cells, front at index zero
   for (genvar i = 0; i < dq_pkg::CAPACITY; i++) begin : g_cell
      logic [dq_pkg::DATA_W-1:0] prev_value;
      logic [dq_pkg::DATA_W-1:0] next_value;
      if (i == 0) begin : g_first
         assign prev_value = req_push_value;
      end else begin : g_mid_prev
         assign prev_value = cell_value[i-1];
      end
      if (i == dq_pkg::CAPACITY - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_mid_next
         assign next_value = cell_value[i+1];
      end
      dq_cell u_cell (
         .clock       (clock),
         .cell_ctrl   (cell_ctrl),
         .cell_index  (dq_pkg::IDX_W'(i)),
         .prev_value  (prev_value),
         .next_value  (next_value),
         .front_value (cell_value[0]),
         .push_value  (req_push_value),
         .value       (cell_value[i]),
         .tap_value   (cell_tap[i])
      );
   end

   // gather the back element: when the deque is not empty, exactly one cell offers it
   always_comb begin
      back_value = '0;
      for (int k = 0; k < dq_pkg::CAPACITY; k++) begin
         back_value = back_value | cell_tap[k];
      end
   end

   dq_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .verbose          (verbose_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .front_value      (cell_value[0]),
      .back_value       (back_value),
      .cell_ctrl        (cell_ctrl),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_value_raw),
      .rsp_last         (rsp_last)
   );

   assign rsp_result_value = rsp_value_raw;

endmodule

// ===== bench/double_ended_queue_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_ended_queue_engine_unit_tb : self-checking bench for the deque engine
// A queue-fed driver issues command beats under random gaps. It predicts
// every result beat at the moment a command is accepted. A monitor with
// random stalls compares each result beat, field by field, with the oldest
// expected one. Phases alternate the verbose and terse dialects through the
// register port, fill the deque past capacity, and end with an exit followed
// by commands that must be ignored.
// ---------------------------------------------------------------------------
module double_ended_queue_engine_unit_tb;

   localparam int QUIET_LIMIT = 2000;
   localparam logic [dq_pkg::ADDR_W-1:0] VERBOSE_MODE_ADDR = 3'd0;
   localparam logic [dq_pkg::OP_W-1:0] UNUSED_OP_LO = 4'd11;
   localparam logic [dq_pkg::OP_W-1:0] UNUSED_OP_HI = 4'd15;
   localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [dq_pkg::DATA_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_type;

   typedef struct packed {
      logic [dq_pkg::OP_W-1:0]          op;
      logic signed [dq_pkg::DATA_W-1:0] value;
   } command_type;

   typedef struct {
      dq_pkg::status_type               status;
      logic signed [dq_pkg::DATA_W-1:0] value;
      logic                             last;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [dq_pkg::OP_W-1:0]           req_opcode = '0;
   logic signed [dq_pkg::DATA_W-1:0]  req_push_value = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [dq_pkg::STAT_W-1:0]         rsp_status;
   logic signed [dq_pkg::DATA_W-1:0]  rsp_result_value;
   logic                              rsp_last;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [dq_pkg::ADDR_W-1:0]         paddr = '0;
   logic [dq_pkg::CSR_DATA_W-1:0]     pwdata = '0;
   logic [dq_pkg::CSR_DATA_W-1:0]     prdata;
   logic                              pready;

   // deque image kept by the predictor
   logic signed [dq_pkg::DATA_W-1:0] stored [dq_pkg::CAPACITY];
   logic [dq_pkg::IDX_W-1:0]         head_slot = '0;
   logic [dq_pkg::CNT_W-1:0]         held_count = '0;
   logic                             halted_flag = 1'b0;
   logic                             verbose_on = 1'b1;

   command_type commands_waiting [$];
   answer_type  answers_due [$];
   int          commands_queued = 0;
   int          commands_accepted = 0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;

   int          feed_gap = 0;
   int          feed_run = 0;
   bit          feed_calm = 1'b0;
   int          drain_gap = 0;
   int          drain_run = 0;
   bit          drain_calm = 1'b0;
   command_type next_cmd;
   answer_type  due;

   double_ended_queue_engine_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   function automatic void owe_answer(input dq_pkg::status_type s,
                                      input logic signed [dq_pkg::DATA_W-1:0] v,
                                      input logic l);
      answer_type a;
      a.status = s;
      a.value  = v;
      a.last   = l;
      answers_due.insert(answers_due.size(), a);
   endfunction

   // advance the deque image by one command and note the beats it owes
   function automatic void deque_apply(input logic [dq_pkg::OP_W-1:0] op,
                                       input logic signed [dq_pkg::DATA_W-1:0] val);
      logic [dq_pkg::IDX_W-1:0] slot;
      int i;
      if (halted_flag) return;
      case (op)
         dq_pkg::OP_PUSHF, dq_pkg::OP_PUSHB: begin
            if (held_count == dq_pkg::CAPACITY) begin
               owe_answer(dq_pkg::STAT_FULL, 64'sd0, 1'b1);
            end else begin
               if (op == dq_pkg::OP_PUSHF) begin
                  head_slot = head_slot - 1'b1;
                  stored[head_slot] = val;
               end else begin
                  slot = head_slot + held_count[dq_pkg::IDX_W-1:0];
                  stored[slot] = val;
               end
               held_count = held_count + 1'b1;
               if (verbose_on) owe_answer(dq_pkg::STAT_OK, 64'sd0, 1'b1);
            end
         end
         dq_pkg::OP_POPF, dq_pkg::OP_POPB, dq_pkg::OP_FRONT, dq_pkg::OP_BACK: begin
            if (held_count == 0) begin
               owe_answer(dq_pkg::STAT_EMPTY_ERR, -64'sd1, 1'b1);
            end else if (op == dq_pkg::OP_POPF || op == dq_pkg::OP_FRONT) begin
               owe_answer(dq_pkg::STAT_VALUE, stored[head_slot], 1'b1);
               if (op == dq_pkg::OP_POPF) begin
                  head_slot = head_slot + 1'b1;
                  held_count = held_count - 1'b1;
               end
            end else begin
               slot = head_slot + held_count[dq_pkg::IDX_W-1:0] - 1'b1;
               owe_answer(dq_pkg::STAT_VALUE, stored[slot], 1'b1);
               if (op == dq_pkg::OP_POPB) held_count = held_count - 1'b1;
            end
         end
         dq_pkg::OP_SIZE:
            owe_answer(dq_pkg::STAT_SIZE,
                       {{(dq_pkg::DATA_W-dq_pkg::CNT_W){1'b0}}, held_count}, 1'b1);
         dq_pkg::OP_EMPTY:
            owe_answer(dq_pkg::STAT_EMPTY_FLAG, (held_count == 0) ? 64'sd1 : 64'sd0, 1'b1);
         dq_pkg::OP_CLEAR: begin
            if (verbose_on) begin
               head_slot = '0;
               held_count = '0;
               owe_answer(dq_pkg::STAT_OK, 64'sd0, 1'b1);
            end
         end
         dq_pkg::OP_PRINT: begin
            if (verbose_on) begin
               if (held_count == 0) begin
                  owe_answer(dq_pkg::STAT_EMPTY_LIST, 64'sd0, 1'b1);
               end else begin
                  for (i = 0; i < held_count; i++) begin
                     slot = head_slot + i[dq_pkg::IDX_W-1:0];
                     owe_answer(dq_pkg::STAT_VALUE, stored[slot], (i + 1 == held_count));
                  end
               end
            end
         end
         dq_pkg::OP_EXIT: begin
            if (verbose_on) begin
               halted_flag = 1'b1;
               owe_answer(dq_pkg::STAT_BYE, 64'sd0, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   // command feed: hold each beat until accepted, then rest for a drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         feed_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            commands_accepted++;
            deque_apply(req_opcode, req_push_value);
            if (feed_run == 0) begin
               feed_run = $urandom_range(0, 40);
               feed_calm = ($urandom_range(0, 2) == 0);
            end else begin
               feed_run = feed_run - 1;
            end
            feed_gap = feed_calm ? 0 : $urandom_range(0, 19);
         end
         if (!req_valid || req_ready) begin
            if (feed_gap != 0) begin
               feed_gap = feed_gap - 1;
               req_valid <= 1'b0;
            end else if (commands_waiting.size() != 0) begin
               next_cmd = commands_waiting[0];
               commands_waiting.delete(0);
               req_valid <= 1'b1;
               req_opcode <= next_cmd.op;
               req_push_value <= next_cmd.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: check each beat, then stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         drain_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat status %0d value %0d last %0b",
                                       rsp_status, rsp_result_value, rsp_last));
            end else begin
               due = answers_due[0];
               answers_due.delete(0);
               if (rsp_status !== due.status)
                  flag_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_status, due.status));
               if (rsp_result_value !== due.value)
                  flag_mismatch($sformatf("value %0d, expected %0d",
                                          rsp_result_value, due.value));
               if (rsp_last !== due.last)
                  flag_mismatch($sformatf("last %0b, expected %0b", rsp_last, due.last));
            end
            if (drain_run == 0) begin
               drain_run = $urandom_range(0, 40);
               drain_calm = ($urandom_range(0, 2) == 0);
            end else begin
               drain_run = drain_run - 1;
            end
            drain_gap = drain_calm ? 0 : $urandom_range(0, 19);
         end
         if (drain_gap != 0) begin
            drain_gap = drain_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // end the run once nothing has moved for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task automatic queue_command(input logic [dq_pkg::OP_W-1:0] op,
                                input logic signed [dq_pkg::DATA_W-1:0] val);
      command_type c;
      c.op = op;
      c.value = val;
      commands_waiting.insert(commands_waiting.size(), c);
      commands_queued++;
   endtask

   function automatic logic signed [dq_pkg::DATA_W-1:0] draw_push_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return 64'sd0;
         3:       return -64'sd1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [dq_pkg::OP_W-1:0] draw_opcode(input mix_type mode,
                                                           input bit allow_exit);
      dq_pkg::op_type queries [4] = '{dq_pkg::OP_FRONT, dq_pkg::OP_BACK,
                                      dq_pkg::OP_SIZE, dq_pkg::OP_EMPTY};
      logic [dq_pkg::OP_W-1:0] push_op;
      logic [dq_pkg::OP_W-1:0] pop_op;
      logic [dq_pkg::OP_W-1:0] query_op;
      logic [dq_pkg::OP_W-1:0] unused_op;
      int roll;
      push_op   = $urandom_range(0, 1) ? dq_pkg::OP_PUSHB : dq_pkg::OP_PUSHF;
      pop_op    = $urandom_range(0, 1) ? dq_pkg::OP_POPB : dq_pkg::OP_POPF;
      query_op  = queries[$urandom_range(0, 3)];
      unused_op = dq_pkg::OP_W'($urandom_range(UNUSED_OP_LO, UNUSED_OP_HI));
      roll = $urandom_range(0, 99);
      case (mode)
         MIX_GROW: begin
            if (roll < 75) return push_op;
            if (roll < 85) return pop_op;
            if (roll < 93) return query_op;
            if (roll < 97) return dq_pkg::OP_PRINT;
            return unused_op;
         end
         MIX_SHRINK: begin
            if (roll < 60) return pop_op;
            if (roll < 75) return push_op;
            if (roll < 90) return query_op;
            if (roll < 95) return dq_pkg::OP_PRINT;
            return unused_op;
         end
         default: begin
            if (roll < 35) return push_op;
            if (roll < 55) return pop_op;
            if (roll < 75) return query_op;
            if (roll < 85) return dq_pkg::OP_PRINT;
            if (roll < 90) return dq_pkg::OP_CLEAR;
            if (roll < 95) return unused_op;
            return allow_exit ? dq_pkg::OP_EXIT : dq_pkg::OP_SIZE;
         end
      endcase
   endfunction

   // random segments that grow, shrink or churn the deque
   task automatic queue_random(input int n, input bit allow_exit);
      int left;
      int seg;
      mix_type mode;
      left = n;
      while (left > 0) begin
         seg = $urandom_range(20, 60);
         if (seg > left) seg = left;
         case ($urandom_range(0, 3))
            0, 1:    mode = MIX_GROW;
            2:       mode = MIX_SHRINK;
            default: mode = MIX_EVEN;
         endcase
         repeat (seg) queue_command(draw_opcode(mode, allow_exit), draw_push_value());
         left -= seg;
      end
   endtask

   // push until full and beyond, whatever the deque held before
   task automatic queue_overfill();
      repeat (dq_pkg::CAPACITY + 3)
         queue_command($urandom_range(0, 1) ? dq_pkg::OP_PUSHB : dq_pkg::OP_PUSHF,
                       draw_push_value());
   endtask

   task automatic settle();
      while (commands_accepted != commands_queued || answers_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_verbose_mode(input logic mode);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= VERBOSE_MODE_ADDR;
      pwdata <= {{(dq_pkg::CSR_DATA_W-1){1'b0}}, mode};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      verbose_on = mode;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // verbose dialect: empty errors, extremes of value, every command but exit
      write_verbose_mode(1'b1);
      queue_command(dq_pkg::OP_POPF, 64'sd0);
      queue_command(dq_pkg::OP_POPB, 64'sd0);
      queue_command(dq_pkg::OP_FRONT, 64'sd0);
      queue_command(dq_pkg::OP_BACK, 64'sd0);
      queue_command(dq_pkg::OP_PRINT, 64'sd0);
      queue_command(dq_pkg::OP_SIZE, 64'sd0);
      queue_command(dq_pkg::OP_EMPTY, 64'sd0);
      queue_command(dq_pkg::OP_PUSHB, VAL_MAX);
      queue_command(dq_pkg::OP_PUSHF, VAL_MIN);
      queue_command(dq_pkg::OP_PUSHB, 64'sd0);
      queue_command(dq_pkg::OP_PUSHF, -64'sd1);
      queue_command(dq_pkg::OP_SIZE, 64'sd0);
      queue_command(dq_pkg::OP_EMPTY, 64'sd0);
      queue_command(dq_pkg::OP_FRONT, 64'sd0);
      queue_command(dq_pkg::OP_BACK, 64'sd0);
      queue_command(dq_pkg::OP_PRINT, 64'sd0);
      queue_command(dq_pkg::OP_POPF, 64'sd0);
      queue_command(dq_pkg::OP_POPB, 64'sd0);
      queue_command(UNUSED_OP_LO, VAL_MAX);
      queue_command(UNUSED_OP_HI, VAL_MIN);
      queue_command(dq_pkg::OP_CLEAR, 64'sd0);
      queue_command(dq_pkg::OP_SIZE, 64'sd0);
      queue_command(dq_pkg::OP_PUSHB, draw_push_value());
      queue_command(dq_pkg::OP_PUSHB, draw_push_value());
      queue_command(dq_pkg::OP_PRINT, 64'sd0);
      settle();

      // terse dialect: exit, clear and print drop; full push still answers
      write_verbose_mode(1'b0);
      queue_command(dq_pkg::OP_EXIT, 64'sd0);
      queue_command(dq_pkg::OP_CLEAR, 64'sd0);
      queue_command(dq_pkg::OP_PRINT, 64'sd0);
      queue_command(dq_pkg::OP_PUSHF, draw_push_value());
      queue_command(dq_pkg::OP_SIZE, 64'sd0);
      queue_overfill();
      queue_command(dq_pkg::OP_SIZE, 64'sd0);
      queue_command(dq_pkg::OP_BACK, 64'sd0);
      queue_command(dq_pkg::OP_POPF, 64'sd0);
      queue_random(60, 1'b1);
      settle();

      // verbose again: full deque listed in one print
      write_verbose_mode(1'b1);
      queue_overfill();
      queue_command(dq_pkg::OP_PRINT, 64'sd0);
      queue_random(130, 1'b0);
      settle();

      write_verbose_mode(1'b0);
      queue_random(50, 1'b1);
      settle();

      // exit halts; everything after it must be ignored
      write_verbose_mode(1'b1);
      queue_random(30, 1'b0);
      queue_command(dq_pkg::OP_EXIT, 64'sd0);
      queue_command(dq_pkg::OP_SIZE, 64'sd0);
      queue_command(dq_pkg::OP_PRINT, 64'sd0);
      queue_command(dq_pkg::OP_PUSHB, draw_push_value());
      queue_random(6, 1'b0);
      settle();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && answers_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== double_ended_queue_engine_unit.f =====
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue_engine_unit.sv
bench/double_ended_queue_engine_unit_tb.sv
